@@ hdl/joystick_event_qualifier_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the joystick event qualifier
// Shared forms for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_EVENT_QUALIFIER_DEFINES_SVH
`define JOYSTICK_EVENT_QUALIFIER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define JEQ_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("joystick_event_qualifier: check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define JEQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("joystick_event_qualifier: check failed");

`endif

@@ hdl/jeq_pkg.sv @@
// ---------------------------------------------------------------------------
// jeq_pkg
// Types and codes shared by the joystick event qualifier modules.
// ---------------------------------------------------------------------------
package jeq_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_AXIS   = 3'd1;
    localparam logic [2:0] REQ_BUTTON = 3'd2;
    localparam logic [2:0] REQ_HAT    = 3'd3;
    localparam logic [2:0] REQ_BALL   = 3'd4;

    // event codes
    localparam logic [1:0] EV_AXIS   = 2'd0;
    localparam logic [1:0] EV_BUTTON = 2'd1;
    localparam logic [1:0] EV_HAT    = 2'd2;
    localparam logic [1:0] EV_BALL   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_AUTO_REPEAT = 2'd0;
    localparam logic [1:0] CFG_DELAY       = 2'd1;
    localparam logic [1:0] CFG_DEADZONES   = 2'd2;
    localparam logic [1:0] CFG_SENS        = 2'd3;

    // one channel's stored state
    typedef struct packed {
        logic [15:0] last;
        logic [31:0] stamp;
    } jeq_entry_t;

    // write-back request from the decision stage
    typedef struct packed {
        logic       en;
        jeq_entry_t data;
    } jeq_wr_t;

    // item held in the decision stage
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  channel;
        logic [15:0] value;
        logic [15:0] dx;
        logic [15:0] dy;
        logic        in_range;
        logic        in_dz;
        logic [15:0] sens;
    } jeq_item_t;

    // result item
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [4:0]  channel;
        logic [15:0] value;
        logic [15:0] dx;
        logic [15:0] dy;
    } jeq_event_t;

endpackage

@@ hdl/jeq_state_mem.sv @@
// ---------------------------------------------------------------------------
// jeq_state_mem
// Per-channel state store: one read, one write, registered read data with
// write-to-read forwarding and reset-cleared entry valid bits.
// ---------------------------------------------------------------------------
module jeq_state_mem #(
    parameter int DEPTH = 40
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  jeq_pkg::jeq_entry_t      wr_data,
    output jeq_pkg::jeq_entry_t      rd_data
);

    jeq_pkg::jeq_entry_t mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    jeq_pkg::jeq_entry_t rd_reg;
    logic                rd_vld_reg;
    logic                fwd_hit_reg;
    jeq_pkg::jeq_entry_t fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg  <= mem[rd_addr];
            fwd_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg  <= vld_reg[rd_addr];
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // an entry never written reads as zero
    assign rd_data = fwd_hit_reg ? fwd_reg : (rd_vld_reg ? rd_reg : '0);

endmodule

@@ hdl/jeq_qualify.sv @@
// ---------------------------------------------------------------------------
// jeq_qualify
// Decision logic: compares a sample with its channel's stored state and
// produces the event and the write-back.
// ---------------------------------------------------------------------------
module jeq_qualify (
    input  jeq_pkg::jeq_item_t  item,
    input  jeq_pkg::jeq_entry_t entry,
    input  logic [31:0]         now_ms,
    input  logic                auto_repeat_on,
    input  logic [15:0]         repeat_delay_ms,
    output jeq_pkg::jeq_event_t ev,
    output jeq_pkg::jeq_wr_t    wr
);

    logic [16:0] delta;
    logic [16:0] delta_mag;
    logic [31:0] elapsed;
    logic        repeat_due;
    logic        lvl;
    logic [3:0]  hat;

    assign delta      = {entry.last[15], entry.last} - {item.value[15], item.value};
    assign delta_mag  = delta[16] ? (17'd0 - delta) : delta;
    assign elapsed    = now_ms - entry.stamp;
    assign repeat_due = elapsed >= {16'd0, repeat_delay_ms};
    assign lvl        = item.value != 16'd0;
    assign hat        = item.value[3:0];

    always_comb begin
        ev            = '0;
        ev.channel    = item.channel;
        wr.en         = 1'b0;
        wr.data.last  = entry.last;
        wr.data.stamp = now_ms;
        case (item.kind)
            jeq_pkg::REQ_AXIS: begin
                ev.kind = jeq_pkg::EV_AXIS;
                if (item.in_range) begin
                    if (item.in_dz) begin
                        ev.valid = 1'b1;
                    end else if (item.value != entry.last) begin
                        wr.en        = 1'b1;
                        wr.data.last = item.value;
                        ev.valid     = delta_mag >= {1'b0, item.sens};
                        ev.value     = item.value;
                    end else if (auto_repeat_on && lvl) begin
                        ev.valid = repeat_due;
                        ev.value = item.value;
                    end else begin
                        wr.en = 1'b1;
                    end
                end
            end
            jeq_pkg::REQ_BUTTON: begin
                ev.kind  = jeq_pkg::EV_BUTTON;
                ev.value = {15'd0, lvl};
                if (item.in_range) begin
                    if (lvl != entry.last[0]) begin
                        wr.en        = 1'b1;
                        wr.data.last = {15'd0, lvl};
                        ev.valid     = 1'b1;
                    end else if (auto_repeat_on && lvl) begin
                        ev.valid = repeat_due;
                    end else begin
                        wr.en = 1'b1;
                    end
                end
            end
            jeq_pkg::REQ_HAT: begin
                ev.kind  = jeq_pkg::EV_HAT;
                ev.value = {12'd0, hat};
                if (item.in_range) begin
                    if (hat != entry.last[3:0]) begin
                        wr.en        = 1'b1;
                        wr.data.last = {12'd0, hat};
                        ev.valid     = 1'b1;
                    end else if (auto_repeat_on && (hat != 4'd0)) begin
                        ev.valid = repeat_due;
                    end else begin
                        wr.en = 1'b1;
                    end
                end
            end
            jeq_pkg::REQ_BALL: begin
                ev.kind  = jeq_pkg::EV_BALL;
                ev.dx    = item.dx;
                ev.dy    = item.dy;
                ev.valid = item.in_range && ((item.dx != 16'd0) || (item.dy != 16'd0));
            end
            default: begin
                ev.valid = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/joystick_event_qualifier.sv @@
// ---------------------------------------------------------------------------
// joystick_event_qualifier
// Turns polled joystick samples and millisecond ticks into change events.
// ---------------------------------------------------------------------------
// The block takes one item per cycle while s_ready is high and gives at most
// one event for it, through the decision stage and the output register. At the
// transfer the channel's entry (last value and restart stamp) is read from
// the state memory; in the decision stage the sample is qualified against it,
// and as it leaves, the entry is written back and the event goes to the output
// register. An item that reads an entry written in the same cycle takes the
// new data from the forwarding path, so back-to-back samples on one channel are exact.
// The output register parts the two sides: while an event waits, the held
// item stalls in the decision stage and the input stays ready only if that
// stage is free. Entries come out of reset as zero through per-entry valid
// bits, so there is no clearing pass. Ticks advance the millisecond clock in
// the decision stage; trackball samples and out-of-range channels leave the
// memory untouched. Write configuration only while the block is idle.
// ---------------------------------------------------------------------------
`include "joystick_event_qualifier_defines.svh"

module joystick_event_qualifier #(
    parameter int AXES    = 4,
    parameter int BUTTONS = 32,
    parameter int HATS    = 4,
    parameter int BALLS   = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    // sample input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [4:0]  s_channel,
    input  logic [15:0] s_sample_value,
    input  logic [15:0] s_ball_dx,
    input  logic [15:0] s_ball_dy,
    // event output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [4:0]  m_event_channel,
    output logic [15:0] m_event_value,
    output logic [15:0] m_event_dx,
    output logic [15:0] m_event_dy
);

    localparam int STAMPS = AXES + BUTTONS + HATS;
    localparam int SLOT_W = $clog2(STAMPS);

    // configuration registers
    logic        auto_repeat_reg;
    logic [15:0] delay_reg;
    logic [63:0] deadzones_reg;
    logic [63:0] sens_reg;

    logic [31:0] now_ms_reg;

    // decision stage
    logic                s1_valid_reg;
    jeq_pkg::jeq_item_t  s1_item_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic                s1_adv;

    // output register
    logic                out_valid_reg;
    jeq_pkg::jeq_event_t out_reg;

    logic                s_accept;
    jeq_pkg::jeq_item_t  item_next;
    logic [SLOT_W-1:0]   slot_next;
    logic [16:0]         sv_x;
    logic [16:0]         mag;
    logic [15:0]         dz;
    logic [1:0]          axis_sel;

    jeq_pkg::jeq_entry_t entry;
    jeq_pkg::jeq_event_t ev;
    jeq_pkg::jeq_wr_t    wr;
    logic                mem_we;

    // hold the decision stage while an event waits to be taken
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign mem_we   = s1_adv && wr.en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_repeat_reg <= 1'b0;
            delay_reg       <= '0;
            deadzones_reg   <= '0;
            sens_reg        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                jeq_pkg::CFG_AUTO_REPEAT: auto_repeat_reg <= cfg_wdata[0];
                jeq_pkg::CFG_DELAY:       delay_reg       <= cfg_wdata[15:0];
                jeq_pkg::CFG_DEADZONES:   deadzones_reg   <= cfg_wdata;
                jeq_pkg::CFG_SENS:        sens_reg        <= cfg_wdata;
                default:                  delay_reg       <= delay_reg;
            endcase
        end
    end

    // Input side: range check, slot of the stamp store, deadzone compare.
    always_comb begin
        axis_sel             = s_channel[1:0];
        dz                   = deadzones_reg[16*axis_sel +: 16];
        sv_x                 = {s_sample_value[15], s_sample_value};
        mag                  = sv_x[16] ? (17'd0 - sv_x) : sv_x;
        item_next.kind       = s_req_type;
        item_next.channel    = s_channel;
        item_next.value      = s_sample_value;
        item_next.dx         = s_ball_dx;
        item_next.dy         = s_ball_dy;
        item_next.in_dz      = mag < {1'b0, dz};
        item_next.sens       = sens_reg[16*axis_sel +: 16];
        item_next.in_range   = 1'b0;
        slot_next            = '0;
        case (s_req_type)
            jeq_pkg::REQ_AXIS: begin
                item_next.in_range = 32'(s_channel) < AXES;
                slot_next          = SLOT_W'(s_channel);
            end
            jeq_pkg::REQ_BUTTON: begin
                item_next.in_range = 32'(s_channel) < BUTTONS;
                slot_next          = SLOT_W'(32'(s_channel) + AXES);
            end
            jeq_pkg::REQ_HAT: begin
                item_next.in_range = 32'(s_channel) < HATS;
                slot_next          = SLOT_W'(32'(s_channel) + AXES + BUTTONS);
            end
            jeq_pkg::REQ_BALL: begin
                item_next.in_range = 32'(s_channel) < BALLS;
            end
            default: begin
                item_next.in_range = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= item_next;
            s1_slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            now_ms_reg    <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            // an item that makes no event still drops a taken one
            if (s1_adv) begin
                out_valid_reg <= ev.valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            // advance the clock as the tick leaves the decision stage
            if (s1_adv && (s1_item_reg.kind == jeq_pkg::REQ_TICK)) begin
                now_ms_reg <= now_ms_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_reg <= ev;
        end
    end

    jeq_state_mem #(
        .DEPTH (STAMPS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (slot_next),
        .wr_en   (mem_we),
        .wr_addr (s1_slot_reg),
        .wr_data (wr.data),
        .rd_data (entry)
    );

    jeq_qualify u_qualify (
        .item            (s1_item_reg),
        .entry           (entry),
        .now_ms          (now_ms_reg),
        .auto_repeat_on  (auto_repeat_reg),
        .repeat_delay_ms (delay_reg),
        .ev              (ev),
        .wr              (wr)
    );

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_reg.kind;
    assign m_event_channel = out_reg.channel;
    assign m_event_value   = out_reg.value;
    assign m_event_dx      = out_reg.dx;
    assign m_event_dy      = out_reg.dy;

    // a stalled input always has an item in the decision stage behind it
    `JEQ_ASSERT_IMPLIES(a_ready_only_when_busy, !s_ready, s1_valid_reg && out_valid_reg)
    // ticks and trackball samples never touch the state memory
    `JEQ_ASSERT_IMPLIES(a_no_write_tick_ball, s1_valid_reg && ((s1_item_reg.kind == jeq_pkg::REQ_TICK) || (s1_item_reg.kind == jeq_pkg::REQ_BALL)), !wr.en)
    // a new event comes only from an item leaving the decision stage
    `JEQ_ASSERT_IMPLIES(a_event_source, $rose(m_valid), $past(s1_adv && ev.valid))
    // a tick leaving the decision stage advances the clock by one
    `JEQ_ASSERT_NEXT(a_tick_advance, s1_adv && (s1_item_reg.kind == jeq_pkg::REQ_TICK), now_ms_reg == 32'($past(now_ms_reg) + 32'd1))

endmodule
